/* rtl/core/dpfl_pkg.sv */
// Package with the sizes, state encoding and control structures of the paging block.
`timescale 1ns / 1ps
package dpfl_pkg;

  localparam int VIRT_PAGES = 16;
  localparam int FRAMES     = 4;
  localparam int PAGE_WORDS = 8;

  localparam int DATA_W  = 32;
  localparam int PAGE_W  = $clog2(VIRT_PAGES);
  localparam int OFFS_W  = $clog2(PAGE_WORDS);
  localparam int ADDR_W  = PAGE_W + OFFS_W;
  localparam int FRAME_W = $clog2(FRAMES);
  localparam int FILL_W  = $clog2(FRAMES + 1);
  localparam int CNT_W   = $clog2(PAGE_WORDS + 1);
  localparam int FWORD_W = FRAME_W + OFFS_W;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESOLVE,
    ST_STORE,
    ST_LOAD,
    ST_ACCESS,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              latch;
    logic              resolve;
    logic              store_en;
    logic              load_en;
    logic [CNT_W-1:0]  cnt;
    logic              access;
    logic              load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic              hit;
    logic              full;
    logic              out_free;
    logic [FILL_W-1:0] fill;
  } stat_t;

endpackage

/* rtl/core/dpfl_req_if.sv */
// Request channel interface: one memory access per transaction.
`timescale 1ns / 1ps
interface dpfl_req_if;
  logic                               valid;
  logic                               ready;
  logic                               mode;
  logic [dpfl_pkg::ADDR_W-1:0]        virt_addr;
  logic signed [dpfl_pkg::DATA_W-1:0] write_value;

  modport source (output valid, mode, virt_addr, write_value, input ready);
  modport sink (input valid, mode, virt_addr, write_value, output ready);
endinterface

/* rtl/core/dpfl_rsp_if.sv */
// Response channel interface: one access result per transaction.
`timescale 1ns / 1ps
interface dpfl_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpfl_pkg::DATA_W-1:0] read_data;
  logic                               page_fault;
  logic [dpfl_pkg::FRAME_W-1:0]       frame_used;
  logic                               evict_valid;
  logic [dpfl_pkg::PAGE_W-1:0]        evicted_page;

  modport source (output valid, read_data, page_fault, frame_used, evict_valid, evicted_page,
                  input ready);
  modport sink (input valid, read_data, page_fault, frame_used, evict_valid, evicted_page,
                output ready);
endinterface

/* rtl/core/dpfl_ctrl.sv */
// Controller state machine that sequences lookup, page copies, access and response.
`timescale 1ns / 1ps
module dpfl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dpfl_pkg::stat_t stat,
  output dpfl_pkg::cmd_t  cmd
);

  dpfl_pkg::state_t             state, state_next;
  logic [dpfl_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                         cnt_last;

  assign cnt_last = (cnt == dpfl_pkg::CNT_W'(dpfl_pkg::PAGE_WORDS));

  // State and word counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpfl_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      dpfl_pkg::ST_IDLE: begin
        if (in_valid) state_next = dpfl_pkg::ST_RESOLVE;
      end
      dpfl_pkg::ST_RESOLVE: begin
        cnt_next = '0;
        if (stat.hit) state_next = dpfl_pkg::ST_ACCESS;
        else if (stat.full) state_next = dpfl_pkg::ST_STORE;
        else state_next = dpfl_pkg::ST_LOAD;
      end
      dpfl_pkg::ST_STORE: begin
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = dpfl_pkg::ST_LOAD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      dpfl_pkg::ST_LOAD: begin
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = dpfl_pkg::ST_ACCESS;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      dpfl_pkg::ST_ACCESS: begin
        state_next = dpfl_pkg::ST_RESP;
      end
      dpfl_pkg::ST_RESP: begin
        if (stat.out_free) state_next = dpfl_pkg::ST_IDLE;
      end
      default: state_next = dpfl_pkg::ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    cmd.cnt  = cnt;
    in_ready = 1'b0;
    unique case (state)
      dpfl_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      dpfl_pkg::ST_RESOLVE: cmd.resolve = 1'b1;
      dpfl_pkg::ST_STORE: cmd.store_en = 1'b1;
      dpfl_pkg::ST_LOAD: cmd.load_en = 1'b1;
      dpfl_pkg::ST_ACCESS: cmd.access = 1'b1;
      dpfl_pkg::ST_RESP: cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/dpfl_dp.sv */
// Datapath: frame directory, order list, frame and backing memories, result register.
`timescale 1ns / 1ps
module dpfl_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  dpfl_pkg::cmd_t                     cmd,
  output dpfl_pkg::stat_t                    stat,
  input  logic                               policy_lru,
  input  logic                               mode,
  input  logic [dpfl_pkg::ADDR_W-1:0]        virt_addr,
  input  logic signed [dpfl_pkg::DATA_W-1:0] write_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dpfl_pkg::DATA_W-1:0] read_data,
  output logic                               page_fault,
  output logic [dpfl_pkg::FRAME_W-1:0]       frame_used,
  output logic                               evict_valid,
  output logic [dpfl_pkg::PAGE_W-1:0]        evicted_page
);

  localparam int FR = dpfl_pkg::FRAMES;
  localparam int FW = dpfl_pkg::FRAME_W;
  localparam int PW = dpfl_pkg::PAGE_W;
  localparam int OW = dpfl_pkg::OFFS_W;
  localparam int LW = dpfl_pkg::FILL_W;
  localparam int DW = dpfl_pkg::DATA_W;
  localparam int FRAME_ENTRIES = dpfl_pkg::FRAMES * dpfl_pkg::PAGE_WORDS;
  localparam int SPACE_ENTRIES = dpfl_pkg::VIRT_PAGES * dpfl_pkg::PAGE_WORDS;

  // Latched transaction.
  logic          mode_q;
  logic [PW-1:0] page_q;
  logic [OW-1:0] offs_q;
  logic [DW-1:0] wval_q;

  // Directory: page held by each frame, replacement order of frames, fill count.
  logic [PW-1:0] frame_page [FR];
  logic [FW-1:0] order [FR];
  logic [LW-1:0] fill;

  // Outcome of the lookup.
  logic [FW-1:0] frame_q;
  logic [PW-1:0] victim_q;
  logic          fault_q;
  logic          evict_q;

  // Memories with per-entry valid bits; an unwritten entry reads as all ones.
  logic [DW-1:0] frame_mem [FRAME_ENTRIES];
  logic [DW-1:0] back_mem [SPACE_ENTRIES];
  logic [FRAME_ENTRIES-1:0] frame_vld;
  logic [SPACE_ENTRIES-1:0] back_vld;
  logic [DW-1:0] fr_rdata, bk_rdata;
  logic          fr_rvld, bk_rvld;
  logic [DW-1:0] fr_word, bk_word;

  logic                        hit;
  logic [FW-1:0]               hit_frame;
  logic [LW-1:0]               pos;
  logic                        pos_found;
  logic [FW-1:0]               ord_lru [FR];
  logic [FW-1:0]               ord_shift [FR];
  logic [FW-1:0]               tail_idx;
  logic [FW-1:0]               victim_frame;
  logic [OW-1:0]               cnt_w;
  logic [OW-1:0]               cnt_prev;
  logic                        cnt_nz;
  logic                        cnt_in;

  assign cnt_w    = cmd.cnt[OW-1:0];
  assign cnt_prev = cnt_w - 1'b1;
  assign cnt_nz   = (cmd.cnt != '0);
  assign cnt_in   = (cmd.cnt < dpfl_pkg::CNT_W'(dpfl_pkg::PAGE_WORDS));
  assign fr_word  = fr_rvld ? fr_rdata : '1;
  assign bk_word  = bk_rvld ? bk_rdata : '1;
  assign victim_frame = order[0];
  assign tail_idx = FW'(fill - 1'b1);

  // Parallel compare of the page against every occupied frame.
  always_comb begin
    hit       = 1'b0;
    hit_frame = '0;
    for (int f = 0; f < FR; f++) begin
      if (LW'(f) < fill && frame_page[f] == page_q) begin
        hit       = 1'b1;
        hit_frame = FW'(f);
      end
    end
  end

  // Position of the hit frame in the order list.
  always_comb begin
    pos       = '0;
    pos_found = 1'b0;
    for (int j = 0; j < FR; j++) begin
      if (!pos_found && LW'(j) < fill && order[j] == hit_frame) begin
        pos       = LW'(j);
        pos_found = 1'b1;
      end
    end
  end

  // Order after moving the hit frame to the tail, and after evicting the head.
  always_comb begin
    for (int j = 0; j < FR; j++) begin
      ord_lru[j] = order[j];
    end
    for (int j = 0; j < FR - 1; j++) begin
      ord_shift[j] = order[j + 1];
      if (LW'(j) >= pos && LW'(j + 1) < fill) ord_lru[j] = order[j + 1];
    end
    ord_shift[FR - 1] = order[0];
    ord_lru[tail_idx] = hit_frame;
  end

  assign stat.hit      = hit;
  assign stat.full     = (fill == LW'(FR));
  assign stat.out_free = !out_valid || out_ready;
  assign stat.fill     = fill;

  // Transaction latch.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q <= mode;
      page_q <= virt_addr[dpfl_pkg::ADDR_W-1:OW];
      offs_q <= virt_addr[OW-1:0];
      wval_q <= write_value;
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.resolve && !hit && fill != LW'(FR)) begin
      fill <= fill + 1'b1;
    end
  end

  // Directory update on lookup.
  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      if (hit) begin
        frame_q  <= hit_frame;
        fault_q  <= 1'b0;
        evict_q  <= 1'b0;
        victim_q <= '0;
        if (policy_lru) order <= ord_lru;
      end else if (fill != LW'(FR)) begin
        frame_q                  <= fill[FW-1:0];
        order[fill[FW-1:0]]      <= fill[FW-1:0];
        frame_page[fill[FW-1:0]] <= page_q;
        fault_q                  <= 1'b1;
        evict_q                  <= 1'b0;
        victim_q                 <= '0;
      end else begin
        frame_q                  <= victim_frame;
        victim_q                 <= frame_page[victim_frame];
        order                    <= ord_shift;
        frame_page[victim_frame] <= page_q;
        fault_q                  <= 1'b1;
        evict_q                  <= 1'b1;
      end
    end
  end

  // Frame memory: read for write-back or access, written by page load or access.
  always_ff @(posedge clk) begin
    if (cmd.store_en && cnt_in) begin
      fr_rdata <= frame_mem[{frame_q, cnt_w}];
      fr_rvld  <= frame_vld[{frame_q, cnt_w}];
    end else if (cmd.access) begin
      fr_rdata <= frame_mem[{frame_q, offs_q}];
      fr_rvld  <= frame_vld[{frame_q, offs_q}];
    end
    if (cmd.load_en && cnt_nz) begin
      frame_mem[{frame_q, cnt_prev}] <= bk_word;
    end else if (cmd.access && mode_q) begin
      frame_mem[{frame_q, offs_q}] <= wval_q;
    end
  end

  // Backing memory: written by write-back, read by page load.
  always_ff @(posedge clk) begin
    if (cmd.load_en && cnt_in) begin
      bk_rdata <= back_mem[{page_q, cnt_w}];
      bk_rvld  <= back_vld[{page_q, cnt_w}];
    end
    if (cmd.store_en && cnt_nz) begin
      back_mem[{victim_q, cnt_prev}] <= fr_word;
    end
  end

  // Valid bits of both memories.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_vld <= '0;
      back_vld  <= '0;
    end else begin
      if (cmd.load_en && cnt_nz) begin
        frame_vld[{frame_q, cnt_prev}] <= 1'b1;
      end else if (cmd.access && mode_q) begin
        frame_vld[{frame_q, offs_q}] <= 1'b1;
      end
      if (cmd.store_en && cnt_nz) begin
        back_vld[{victim_q, cnt_prev}] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data    <= mode_q ? wval_q : fr_word;
      page_fault   <= fault_q;
      frame_used   <= frame_q;
      evict_valid  <= evict_q;
      evicted_page <= evict_q ? victim_q : '0;
    end
  end

endmodule

/* rtl/core/demand_paging_fifo_lru.sv */
// Top level of the demand paging block with FIFO or LRU page replacement.
// Each request transaction reads or writes one word of a 16-page virtual space kept in
// 4 frames and returns one response transaction. A hit copies no page; a fault into a
// free frame first loads the page, one word per cycle from the backing-memory read
// port, registering each read word before it is written to the frame; a fault with
// eviction first writes the victim page back over the frame-memory read port. One
// request is in flight at a time; the next is accepted as soon as the result sits in
// the output register. The user must write policy_lru through cfg_we and cfg_wdata only
// while the block is idle, which it does not enforce; it applies from the next request.
`timescale 1ns / 1ps
module demand_paging_fifo_lru (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  dpfl_req_if.sink      req,
  dpfl_rsp_if.source    rsp
);

  dpfl_pkg::cmd_t  cmd;
  dpfl_pkg::stat_t stat;
  logic            policy_lru;

  // Policy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_lru <= 1'b0;
    end else if (cfg_we) begin
      policy_lru <= cfg_wdata;
    end
  end

  dpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dpfl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .policy_lru   (policy_lru),
    .mode         (req.mode),
    .virt_addr    (req.virt_addr),
    .write_value  (req.write_value),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .read_data    (rsp.read_data),
    .page_fault   (rsp.page_fault),
    .frame_used   (rsp.frame_used),
    .evict_valid  (rsp.evict_valid),
    .evicted_page (rsp.evicted_page)
  );

`ifndef SYNTHESIS
  // The fill count never passes the number of frames.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    stat.fill <= dpfl_pkg::FILL_W'(dpfl_pkg::FRAMES))
    else $error("fill count exceeds frame count");

  // An eviction only happens on a page fault.
  a_evict_fault: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.evict_valid |-> rsp.page_fault)
    else $error("eviction reported without page fault");

  // A response without an eviction reports page zero.
  a_evict_page: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.evict_valid |-> rsp.evicted_page == '0)
    else $error("evicted page set without eviction");

  // Reset leaves no response pending.
  a_reset_out: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid after reset");
`endif

endmodule
